@@ sv/plsf_pkg.sv @@
// Shared types, constants and saturating helpers for the polynomial least-squares fit core.
// Used by plsf_arith, plsf_dp, plsf_ctrl and the top level; depends on nothing.
package plsf_pkg;

	localparam int MAX_DEGREE      = 7;
	localparam int NCOEF           = MAX_DEGREE + 1;
	localparam int NPOW            = 2 * MAX_DEGREE + 1;
	localparam int DEG_W           = 3;
	localparam int COL_W           = 4;
	localparam int IN_W            = 16;
	localparam int VAL_W           = 64;
	localparam int DEF_MAX_SAMPLES = 256;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [4:0] {
		S_IDLE, S_ACC, S_ACC_END, S_LOAD, S_CLEAR, S_PIV_RD, S_PIV_CHK,
		S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_F_RD, S_F_CAP, S_E_RDA, S_E_RDC,
		S_E_MUL, S_E_WAIT, S_EM_RD, S_EM_CAP, S_EM_OUT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_CAPTURE, OP_ACC, OP_LOAD, OP_CLEAR, OP_CAP_PIV, OP_DIV_START,
		OP_WR_RES, OP_CAP_F, OP_CAP_A, OP_MUL_START, OP_WR_SUB, OP_CAP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} arith_state_t;

	typedef struct packed {
		dp_op_t             op;
		logic [DEG_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               flag;
		logic               last;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic rd_zero;
		logic done;
	} dp_stat_t;

	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W-1:0] r;
		r = a + b;
		if (a[VAL_W-1] == b[VAL_W-1] && r[VAL_W-1] != a[VAL_W-1])
			r = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_sub(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W-1:0] r;
		r = a - b;
		if (a[VAL_W-1] != b[VAL_W-1] && r[VAL_W-1] != a[VAL_W-1])
			r = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] from_mag(input logic neg,
			input logic [VAL_W-1:0] m);
		logic signed [VAL_W-1:0] r;
		if (neg)
			r = m[VAL_W-1] ? VAL_MIN : -$signed(m);
		else
			r = m[VAL_W-1] ? VAL_MAX : $signed(m);
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] x);
		return x[VAL_W-1] ? 0 - $unsigned(x) : $unsigned(x);
	endfunction

endpackage

@@ sv/plsf_arith.sv @@
// Multi-cycle Q32.32 unit: product rounded half away from zero (four 32x32 partial
// products) or restoring quotient (one bit a cycle), both saturated. Uses plsf_pkg.
module plsf_arith import plsf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    is_div,
	input  logic signed [VAL_W-1:0] a,
	input  logic signed [VAL_W-1:0] b,
	output logic                    done,
	output logic signed [VAL_W-1:0] res
);

	arith_state_t      state_q;
	logic [6:0]        cnt_q;
	logic [VAL_W-1:0]  x_q, y_q, r_q, quo_q;
	logic [127:0]      acc_q;
	logic [63:0]       pp_s1;
	logic [1:0]        sh_s1;
	logic              pv_q, neg_q, ovf_q, div_q, done_q;
	logic signed [VAL_W-1:0] res_q;

	logic [VAL_W-1:0]  ma, mb;
	logic [31:0]       xs, ys;
	logic [127:0]      pp_sh;
	logic [VAL_W:0]    r2;
	logic              sat;
	logic [VAL_W-1:0]  m_sel;

	always_comb begin
		ma = mag(a);
		mb = mag(b);
		xs = cnt_q[0] ? x_q[63:32] : x_q[31:0];
		ys = cnt_q[1] ? y_q[63:32] : y_q[31:0];
		case (sh_s1)
			2'd0:    pp_sh = {64'b0, pp_s1};
			2'd1:    pp_sh = {32'b0, pp_s1, 32'b0};
			default: pp_sh = {pp_s1, 64'b0};
		endcase
		r2 = {r_q, x_q[VAL_W-1]};
		sat = div_q ? ovf_q : (acc_q[127:96] != 32'b0);
		m_sel = div_q ? quo_q : acc_q[95:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == A_FIN);
			unique case (state_q)
				A_IDLE: begin
					cnt_q <= '0;
					pv_q  <= 1'b0;
					if (start) begin
						if (is_div)
							state_q <= ({32'b0, ma[63:32]} >= mb) ? A_FIN : A_DIV;
						else
							state_q <= A_MUL;
					end
				end
				A_MUL: begin
					pv_q  <= (cnt_q < 7'd4);
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd4) state_q <= A_FIN;
				end
				A_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= A_FIN;
				end
				A_FIN: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && start) begin
			neg_q <= a[VAL_W-1] ^ b[VAL_W-1];
			div_q <= is_div;
			y_q   <= mb;
			quo_q <= '0;
			ovf_q <= is_div && ({32'b0, ma[63:32]} >= mb);
			if (is_div) begin
				x_q <= {ma[31:0], 32'b0};
				r_q <= {32'b0, ma[63:32]};
			end else begin
				x_q <= ma;
				// seed with the rounding half
				acc_q <= 128'h8000_0000;
			end
		end
		if (state_q == A_MUL) begin
			if (cnt_q < 7'd4) begin
				pp_s1 <= 64'(xs) * 64'(ys);
				sh_s1 <= 2'({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]});
			end
			if (pv_q) acc_q <= acc_q + pp_sh;
		end
		if (state_q == A_DIV) begin
			x_q <= {x_q[VAL_W-2:0], 1'b0};
			if (r2 >= {1'b0, y_q}) begin
				r_q   <= VAL_W'(r2 - {1'b0, y_q});
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				r_q   <= r2[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
		if (state_q == A_FIN)
			res_q <= sat ? (neg_q ? VAL_MIN : VAL_MAX) : from_mag(neg_q, m_sel);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ sv/plsf_dp.sv @@
// Datapath: power and moment sums, augmented matrix memory, arithmetic unit and
// output registers, all driven by a command from plsf_ctrl. Uses plsf_pkg, plsf_arith.
module plsf_dp import plsf_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                st,
	input  logic signed [IN_W-1:0]  in_t,
	input  logic signed [IN_W-1:0]  in_b,
	output logic [DEG_W-1:0]        out_idx,
	output logic signed [VAL_W-1:0] out_val,
	output logic                    out_sing,
	output logic                    out_last
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int MEM_D = NCOEF * (1 << COL_W);

	logic signed [VAL_W-1:0] ps_q [NPOW];
	logic signed [VAL_W-1:0] ms_q [NCOEF];
	logic [CNT_W-1:0]        cnt_q;
	logic signed [IN_W-1:0]  t_q, b_q;
	logic signed [31:0]      p_q, pw_s1;
	logic signed [47:0]      mb_s1;
	logic [COL_W-1:0]        k_s1;
	logic                    v_s1;

	logic [VAL_W-1:0] mat_mem [MEM_D];
	logic signed [VAL_W-1:0] rd_q, piv_q, f_q, a_q, c_q;

	logic signed [47:0] pt, pt_r, mb_r;
	logic signed [VAL_W-1:0] pw_ext, mr_ext, wdata, ar_a, ar_b, ar_res;
	logic [COL_W-1:0] pidx;
	logic [DEG_W+COL_W-1:0] addr;
	logic we, ar_start, ar_done;

	always_comb begin
		pt     = $signed(p_q) * $signed(t_q);
		pt_r   = pt + 48'sd16384;
		mb_r   = mb_s1 + 48'sd4096;
		pw_ext = {{(VAL_W-34){pw_s1[31]}}, pw_s1, 2'b0};
		mr_ext = {{(VAL_W-35){mb_r[47]}}, mb_r[47:13]};
		pidx   = {1'b0, cmd.row} + cmd.col;
		addr   = {cmd.row, cmd.col};
		we     = (cmd.op == OP_LOAD) || (cmd.op == OP_WR_RES) || (cmd.op == OP_WR_SUB);
		case (cmd.op)
			OP_LOAD:   wdata = cmd.flag ? ms_q[cmd.row] : ps_q[pidx];
			OP_WR_RES: wdata = ar_res;
			default:   wdata = sat_sub(c_q, ar_res);
		endcase
		ar_start = (cmd.op == OP_DIV_START) || (cmd.op == OP_MUL_START);
		ar_a     = (cmd.op == OP_DIV_START) ? rd_q : f_q;
		ar_b     = (cmd.op == OP_DIV_START) ? piv_q : a_q;
	end

	// sums and sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPOW; i++) ps_q[i] <= '0;
			for (int i = 0; i < NCOEF; i++) ms_q[i] <= '0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= (cmd.op == OP_ACC);
			if (cmd.op == OP_CLEAR) begin
				for (int i = 0; i < NPOW; i++) ps_q[i] <= '0;
				for (int i = 0; i < NCOEF; i++) ms_q[i] <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.op == OP_CAPTURE && !st.full) cnt_q <= cnt_q + 1'b1;
				if (v_s1) begin
					ps_q[k_s1] <= sat_add(ps_q[k_s1], pw_ext);
					if (k_s1 < COL_W'(NCOEF))
						ms_q[k_s1[DEG_W-1:0]] <= sat_add(ms_q[k_s1[DEG_W-1:0]], mr_ext);
				end
			end
		end
	end

	// power chain: one multiply per power, sums updated in the cycle after
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			t_q <= in_t;
			b_q <= in_b;
			p_q <= 32'sh4000_0000;
		end
		if (cmd.op == OP_ACC) begin
			pw_s1 <= p_q;
			mb_s1 <= $signed(p_q) * $signed(b_q);
			k_s1  <= cmd.col;
			p_q   <= pt_r[46:15];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mat_mem[addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rd_q <= mat_mem[addr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAP_PIV:   piv_q <= rd_q;
			OP_CAP_F:     f_q   <= rd_q;
			OP_CAP_A:     a_q   <= rd_q;
			OP_MUL_START: c_q   <= rd_q;
			OP_CAP_OUT: begin
				out_idx  <= cmd.row;
				out_val  <= cmd.flag ? '0 : rd_q;
				out_sing <= cmd.flag;
				out_last <= cmd.last;
			end
			default: ;
		endcase
	end

	plsf_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ar_start),
		.is_div (cmd.op == OP_DIV_START),
		.a      (ar_a),
		.b      (ar_b),
		.done   (ar_done),
		.res    (ar_res)
	);

	assign st.full    = (cnt_q == CNT_W'(MAX_SAMPLES));
	assign st.rd_zero = (rd_q == '0);
	assign st.done    = ar_done;

endmodule

@@ sv/plsf_ctrl.sv @@
// Sequencer: accumulation steps, matrix load, Gauss-Jordan elimination and
// coefficient output, issued as commands to plsf_dp. Uses plsf_pkg.
module plsf_ctrl import plsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DEG_W-1:0] degree,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  dp_stat_t         st,
	output dp_cmd_t          cmd
);

	ctrl_state_t state_q, state_d;
	logic [DEG_W-1:0] i_q, j_q;
	logic [COL_W-1:0] k_q;
	logic last_q, sing_q;

	logic [COL_W-1:0] n, deg4, i4, j_first, j_nx, j_after;
	logic k_end, i_end;

	always_comb begin
		deg4    = {1'b0, degree};
		n       = deg4 + 1'b1;
		i4      = {1'b0, i_q};
		j_first = (i_q == '0) ? COL_W'(1) : '0;
		j_nx    = {1'b0, j_q} + 1'b1;
		j_after = (j_nx == i4) ? j_nx + 1'b1 : j_nx;
		k_end   = (k_q == n);
		i_end   = (i_q == degree);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (s_tvalid) begin
					if (!st.full) state_d = S_ACC;
					else if (s_tlast) state_d = S_LOAD;
				end
			S_ACC:      if (k_q == COL_W'(NPOW - 1)) state_d = S_ACC_END;
			S_ACC_END:  state_d = last_q ? S_LOAD : S_IDLE;
			S_LOAD:     if (k_end && i_end) state_d = S_CLEAR;
			S_CLEAR:    state_d = S_PIV_RD;
			S_PIV_RD:   state_d = S_PIV_CHK;
			S_PIV_CHK:  state_d = st.rd_zero ? S_EM_RD : S_DIV_RD;
			S_DIV_RD:   state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT:
				if (st.done) begin
					if (!k_end) state_d = S_DIV_RD;
					else if (j_first <= deg4) state_d = S_F_RD;
					else state_d = i_end ? S_EM_RD : S_PIV_RD;
				end
			S_F_RD:     state_d = S_F_CAP;
			S_F_CAP:    state_d = S_E_RDA;
			S_E_RDA:    state_d = S_E_RDC;
			S_E_RDC:    state_d = S_E_MUL;
			S_E_MUL:    state_d = S_E_WAIT;
			S_E_WAIT:
				if (st.done) begin
					if (!k_end) state_d = S_E_RDA;
					else if (j_after <= deg4) state_d = S_F_RD;
					else state_d = i_end ? S_EM_RD : S_PIV_RD;
				end
			S_EM_RD:    state_d = S_EM_CAP;
			S_EM_CAP:   state_d = S_EM_OUT;
			S_EM_OUT:
				if (m_tready) state_d = (k_q == deg4) ? S_IDLE : S_EM_RD;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '{op: OP_NOP, row: i_q, col: k_q, flag: 1'b0, last: 1'b0};
		s_tready = (state_q == S_IDLE);
		m_tvalid = (state_q == S_EM_OUT);
		unique case (state_q)
			S_IDLE:     if (s_tvalid) cmd.op = OP_CAPTURE;
			S_ACC:      cmd.op = OP_ACC;
			S_LOAD: begin
				cmd.op   = OP_LOAD;
				cmd.flag = k_end;
			end
			S_CLEAR:    cmd.op = OP_CLEAR;
			S_PIV_RD:   cmd.col = i4;
			S_PIV_CHK:  cmd.op = OP_CAP_PIV;
			S_DIV_GO:   cmd.op = OP_DIV_START;
			S_DIV_WAIT: if (st.done) cmd.op = OP_WR_RES;
			S_F_RD: begin
				cmd.row = j_q;
				cmd.col = i4;
			end
			S_F_CAP:    cmd.op = OP_CAP_F;
			S_E_RDC: begin
				cmd.op  = OP_CAP_A;
				cmd.row = j_q;
			end
			S_E_MUL:    cmd.op = OP_MUL_START;
			S_E_WAIT: begin
				cmd.row = j_q;
				if (st.done) cmd.op = OP_WR_SUB;
			end
			S_EM_RD: begin
				cmd.row = k_q[DEG_W-1:0];
				cmd.col = n;
			end
			S_EM_CAP: begin
				cmd.op   = OP_CAP_OUT;
				cmd.row  = k_q[DEG_W-1:0];
				cmd.flag = sing_q;
				cmd.last = (k_q == deg4);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
			sing_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE:
					if (s_tvalid) begin
						last_q <= s_tlast;
						sing_q <= 1'b0;
						i_q    <= '0;
						k_q    <= '0;
					end
				S_ACC:      k_q <= (k_q == COL_W'(NPOW - 1)) ? '0 : k_q + 1'b1;
				S_LOAD:
					if (k_end) begin
						k_q <= '0;
						i_q <= i_end ? '0 : i_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				S_CLEAR:    i_q <= '0;
				S_PIV_CHK: begin
					k_q <= '0;
					if (st.rd_zero) sing_q <= 1'b1;
				end
				S_DIV_WAIT:
					if (st.done) begin
						if (!k_end) k_q <= k_q + 1'b1;
						else begin
							k_q <= '0;
							if (j_first <= deg4) j_q <= j_first[DEG_W-1:0];
							else if (!i_end) i_q <= i_q + 1'b1;
						end
					end
				S_F_CAP:    k_q <= '0;
				S_E_WAIT:
					if (st.done) begin
						if (!k_end) k_q <= k_q + 1'b1;
						else begin
							k_q <= '0;
							if (j_after <= deg4) j_q <= j_after[DEG_W-1:0];
							else if (!i_end) i_q <= i_q + 1'b1;
						end
					end
				S_EM_OUT:   if (m_tready) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ sv/polynomial_least_squares_fit_core.sv @@
// Top level of the polynomial least-squares fit: degree register, sequencer and datapath.
// Depends on plsf_pkg, plsf_ctrl, plsf_dp.
//
//  channel  | signals                          | meaning
//  cfg      | cfg_wen, cfg_wdata               | polynomial degree, 0..7
//  s (in)   | s_tvalid/s_tready/s_tdata/s_tlast| one sample (t, b), tlast ends the run
//  m (out)  | m_tvalid/m_tready/m_tdata/...    | one fitted coefficient, lowest order first
//
// A sample is handled as a capture, one step per power t^0..t^14 on the shared
// multiplier, and a final sum update. After a last sample the solve loads the
// (n x n+1) matrix, then divides each element of the pivot row and does a
// multiply-subtract for each element of the other rows; each coefficient then
// goes through read, capture and present, held in present while m_tready is low.
// Reset clears the sums, the count and the degree (to 1); s_tready stays low from
// acceptance until the sample's sums are updated, and after a last sample until all coefficients have been taken.
module polynomial_least_squares_fit_core import plsf_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_t[15:0], sample_b[31:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // coef_index[2:0], coef_value[66:3], zero[71:67]
	output logic        m_tuser,   // singular
	output logic        m_tlast
);

	logic [DEG_W-1:0] degree_q;
	dp_cmd_t  cmd;
	dp_stat_t st;
	logic [DEG_W-1:0] out_idx;
	logic signed [VAL_W-1:0] out_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) degree_q <= DEG_W'(1);
		else if (cfg_wen) degree_q <= cfg_wdata;
	end

	plsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.degree   (degree_q),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	plsf_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_t     (s_tdata[15:0]),
		.in_b     (s_tdata[31:16]),
		.out_idx  (out_idx),
		.out_val  (out_val),
		.out_sing (m_tuser),
		.out_last (m_tlast)
	);

	assign m_tdata = {5'b0, out_val, out_idx};

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a coefficient is pending");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("coefficient after the last one of the run");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[66:3] == '0))
		else $error("singular run with nonzero coefficient");

endmodule

@@ tb/plsf_checker.sv @@
// Coefficient checker for the polynomial least-squares fit core.
// Watches the sample and coefficient streams, predicts the fit and compares.
// Depends on plsf_pkg.
module plsf_checker import plsf_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          coefs_pending
);

	typedef struct packed {
		logic [2:0]  idx;
		logic [63:0] value;
		logic        sing;
		logic        last;
	} coef_t;

	localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	coef_t       coef_q[$];
	logic [63:0] pow_acc[NPOW];
	logic [63:0] mom_acc[NCOEF];
	logic [63:0] mat[NCOEF][NCOEF+1];
	int          n_acc;
	logic [2:0]  deg;

	assign coefs_pending = coef_q.size();

	function automatic logic [63:0] s_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [63:0] s_sub(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [63:0] abs64(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	function automatic logic [63:0] signed_of(logic neg, logic [63:0] m);
		if (neg) return m[63] ? S64_MIN : -m;
		return m[63] ? S64_MAX : m;
	endfunction

	// floor division by 2^s of a signed value
	function automatic logic [63:0] shr_floor(logic [63:0] x, int s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		logic neg;
		neg = a[63] ^ b[63];
		p = abs64(a) * abs64(b) + 128'h8000_0000;
		if (p[127:96] != 0) return neg ? S64_MIN : S64_MAX;
		return signed_of(neg, p[95:32]);
	endfunction

	function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] d);
		logic [127:0] q;
		logic neg;
		neg = a[63] ^ d[63];
		if ((abs64(a) >> 32) >= abs64(d)) return neg ? S64_MIN : S64_MAX;
		q = {32'd0, abs64(a), 32'd0} / {64'd0, abs64(d)};
		return signed_of(neg, q[63:0]);
	endfunction

	task automatic clear_sums();
		for (int k = 0; k < NPOW; k++) pow_acc[k] = 0;
		for (int k = 0; k < NCOEF; k++) mom_acc[k] = 0;
		n_acc = 0;
	endtask

	task automatic add_sample(logic signed [15:0] t, logic signed [15:0] b);
		logic [63:0] p;
		p = 64'd1 << 30;
		for (int k = 0; k < NPOW; k++) begin
			if (k > 0) p = shr_floor(p * {{48{t[15]}}, t} + (64'd1 << 14), 15);
			pow_acc[k] = s_add(pow_acc[k], p << 2);
			if (k < NCOEF)
				mom_acc[k] = s_add(mom_acc[k],
					shr_floor(p * {{48{b[15]}}, b} + (64'd1 << 12), 13));
		end
	endtask

	task automatic predict_fit();
		int n;
		logic sing;
		logic [63:0] pv, f;
		n = deg + 1;
		sing = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) mat[i][j] = pow_acc[i+j];
			mat[i][n] = mom_acc[i];
		end
		for (int i = 0; i < n && !sing; i++) begin
			pv = mat[i][i];
			if (pv == 0) begin
				sing = 1;
			end else begin
				for (int k = 0; k <= n; k++) mat[i][k] = fx_div(mat[i][k], pv);
				for (int j = 0; j < n; j++) begin
					if (j != i) begin
						f = mat[j][i];
						for (int k = 0; k <= n; k++) mat[j][k] = s_sub(mat[j][k], fx_mul(f, mat[i][k]));
					end
				end
			end
		end
		for (int k = 0; k < n; k++)
			coef_q.push_back('{k[2:0], sing ? 64'd0 : mat[k][n], sing, k == n - 1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		coef_t want;
		if (!arst_n) begin
			clear_sums();
			deg = 3'd1;
			fail_count = 0;
			coef_q.delete();
		end else begin
			if (cfg_wen) deg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (n_acc < MAX_SAMPLES) begin
					add_sample(s_tdata[15:0], s_tdata[31:16]);
					n_acc++;
				end
				if (s_tlast) begin
					predict_fit();
					clear_sums();
				end
			end
			if (m_tvalid && m_tready) begin
				if (coef_q.size() == 0) begin
					$display("%0t: unexpected coefficient idx=%0d value=%h", $time,
						m_tdata[2:0], m_tdata[66:3]);
					fail_count++;
				end else begin
					want = coef_q.pop_front();
					if (want.idx != m_tdata[2:0] || want.value != m_tdata[66:3]
							|| want.sing != m_tuser || want.last != m_tlast
							|| m_tdata[71:67] != 0) begin
						$display("%0t: mismatch expected idx=%0d val=%h sing=%b last=%b",
							$time, want.idx, want.value, want.sing, want.last);
						$display("%0t:          actual   idx=%0d val=%h sing=%b last=%b pad=%h",
							$time, m_tdata[2:0], m_tdata[66:3], m_tuser, m_tlast,
							m_tdata[71:67]);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ tb/tb.sv @@
// Testbench top for polynomial_least_squares_fit_core: clock, reset, degree
// settings, sample stimulus and verdict. Depends on the core and plsf_checker.
module tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wen = 0;
	logic [2:0]  cfg_wdata = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = 0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          coefs_pending;
	logic        stall_on = 1;

	always #4 clk = ~clk;

	polynomial_least_squares_fit_core u_dut (.*);
	plsf_checker u_chk (.*);

	function automatic int gap_len();
		if (!stall_on) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
		return 0;
	endfunction

	// hold tready low for random stretches
	always @(negedge clk) begin
		int g;
		g = gap_len();
		if (g > 0) begin
			m_tready <= 0;
			repeat (g) @(negedge clk);
		end
		m_tready <= 1;
	end

	// tvalid stays high on return; the next call or the caller drops it
	task automatic push_sample(logic [15:0] t, logic [15:0] b, logic last);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {b, t};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_set(logic [2:0] d);
		s_tvalid <= 0;
		while (coefs_pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		cfg_wen <= 1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_wen <= 0;
	endtask

	function automatic logic [15:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int len;
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: reset degree 1, then extremes and special cases
		push_sample(16'h0000, 16'h0000, 0);
		push_sample(16'h4000, 16'h2000, 0);
		push_sample(16'hc000, 16'he000, 1);
		// single sample: singular at degree 1
		push_sample(16'h7fff, 16'h7fff, 1);
		drain_and_set(3'd0);
		push_sample(16'h8000, 16'h8000, 0);
		push_sample(16'h7fff, 16'h7fff, 1);
		drain_and_set(3'd7);
		for (int i = 0; i < 8; i++)
			push_sample(16'(i * 8000 - 28000), 16'(i * 3000), i == 7);
		push_sample(16'h1234, 16'hfedc, 1);
		drain_and_set(3'd2);
		// overflow the sample count
		for (int i = 0; i < 260; i++) push_sample(rnd_val(), rnd_val(), i == 259);
		// random runs
		for (int r = 0; r < 40; r++) begin
			drain_and_set(3'($urandom_range(0, 7)));
			stall_on = (r % 7) != 3;
			len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
			for (int i = 0; i < len; i++) begin
				// samples of the run, at the degree set before it
				push_sample(rnd_val(), rnd_val(), i == len - 1);
			end
		end
		s_tvalid <= 0;
		stall_on = 1;
		while (coefs_pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#200000000;
		$display("tb: errors");
		$finish;
	end

endmodule
